// File: hw/rtl/ldwp_pkg.sv
// Shared types, widths and register codes for the LD window pruner.
package ldwp_pkg;

    localparam int GENO_W     = 2;
    localparam int SUM_W      = 14;
    localparam int SSQ_W      = 23;
    localparam int FREQ_W     = 16;
    localparam int THR_W      = 17;
    localparam int CNT_W      = 13;
    localparam int WU_W       = 5;
    localparam int DOT_W      = 15;
    localparam int IDX_W      = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [GENO_W-1:0] GENO_MISSING = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_USED  = 2'd2;

    localparam logic [THR_W-1:0] THR_RESET = 17'd13107;
    localparam logic [CNT_W-1:0] CNT_RESET = 13'd4096;
    localparam logic [WU_W-1:0]  WU_RESET  = 5'd16;

    localparam int R2_LAT = 5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_WALK_CHECK,
        S_WALK_WAIT,
        S_CLOSE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic acc;
        logic walk_init;
        logic walk_next;
        logic test_issue;
        logic walk_apply;
        logic close;
        logic pop;
        logic finish;
    } t_ctl_cmd;

    typedef struct packed {
        logic col_end;
        logic cur_kept;
        logic walk_done;
        logic slot_kept;
        logic hit_valid;
        logic emit_more;
        logic out_free;
    } t_dp_status;

endpackage

// File: hw/rtl/ldwp_r2_test.sv
// Pipelined r2 threshold test for one SNP pair, integer form without division.
module ldwp_r2_test (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_issue,
    input  logic [ldwp_pkg::DOT_W-1:0]   i_dot,
    input  logic [ldwp_pkg::SUM_W-1:0]   i_sum_j,
    input  logic [ldwp_pkg::SUM_W-1:0]   i_sum_k,
    input  logic [ldwp_pkg::SSQ_W-1:0]   i_ssq_j,
    input  logic [ldwp_pkg::SSQ_W-1:0]   i_ssq_k,
    input  logic [ldwp_pkg::THR_W-1:0]   i_thr,
    input  logic [ldwp_pkg::CNT_W-1:0]   i_n,
    output logic                         o_hit_valid,
    output logic                         o_hit
);
    import ldwp_pkg::*;

    localparam int DN_W   = DOT_W + CNT_W;
    localparam int SS_W   = 2 * SUM_W;
    localparam int PROD_W = (DN_W > SS_W) ? DN_W : SS_W;
    localparam int D_W    = PROD_W + 1;
    localparam int TN_W   = THR_W + CNT_W;
    localparam int TNN_W  = TN_W + CNT_W;
    localparam int QQ_W   = 2 * SSQ_W;
    localparam int A_LO_W = (TNN_W + 1) / 2;
    localparam int A_HI_W = TNN_W - A_LO_W;
    localparam int B_LO_W = (QQ_W + 1) / 2;
    localparam int B_HI_W = QQ_W - B_LO_W;
    localparam int RHS_W  = TNN_W + QQ_W;
    localparam int D2_W   = 2 * PROD_W;
    localparam int CMP_W  = (RHS_W > D2_W + 32) ? RHS_W : D2_W + 32;

    logic [R2_LAT-1:0] r_vld;

    logic [DN_W-1:0]  r_p_dn;
    logic [SS_W-1:0]  r_p_ss;
    logic [TN_W-1:0]  r_p_tn;
    logic [QQ_W-1:0]  r_p_qq;
    logic [CNT_W-1:0] r_n1;

    logic [PROD_W-1:0] r_ad;
    logic [TNN_W-1:0]  r_p_tnn;
    logic [QQ_W-1:0]   r_qq2;

    logic [D2_W-1:0]            r_d2;
    logic [A_LO_W+B_LO_W-1:0]   r_pp00;
    logic [A_LO_W+B_HI_W-1:0]   r_pp01;
    logic [A_HI_W+B_LO_W-1:0]   r_pp10;
    logic [A_HI_W+B_HI_W-1:0]   r_pp11;

    logic [D2_W-1:0]  r_d2b;
    logic [RHS_W-1:0] r_rhs;
    logic             r_hit;

    logic [D_W-1:0]    d_diff;
    logic [PROD_W-1:0] d_abs;
    logic [CMP_W-1:0]  lhs_cmp;
    logic [CMP_W-1:0]  rhs_cmp;

    always_comb begin
        d_diff = D_W'(r_p_dn) - D_W'(r_p_ss);
        if (d_diff[D_W-1]) begin
            d_abs = PROD_W'(-d_diff);
        end else begin
            d_abs = PROD_W'(d_diff);
        end
        lhs_cmp = CMP_W'({r_d2b, 32'b0});
        rhs_cmp = CMP_W'(r_rhs);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[R2_LAT-2:0], i_issue};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_issue) begin
            r_p_dn <= DN_W'(i_dot) * DN_W'(i_n);
            r_p_ss <= SS_W'(i_sum_j) * SS_W'(i_sum_k);
            r_p_tn <= TN_W'(i_thr) * TN_W'(i_n);
            r_p_qq <= QQ_W'(i_ssq_j) * QQ_W'(i_ssq_k);
            r_n1   <= i_n;
        end
        r_ad    <= d_abs;
        r_p_tnn <= TNN_W'(r_p_tn) * TNN_W'(r_n1);
        r_qq2   <= r_p_qq;

        r_d2   <= D2_W'(r_ad) * D2_W'(r_ad);
        r_pp00 <= (A_LO_W+B_LO_W)'(r_p_tnn[A_LO_W-1:0]) * (A_LO_W+B_LO_W)'(r_qq2[B_LO_W-1:0]);
        r_pp01 <= (A_LO_W+B_HI_W)'(r_p_tnn[A_LO_W-1:0]) * (A_LO_W+B_HI_W)'(r_qq2[QQ_W-1:B_LO_W]);
        r_pp10 <= (A_HI_W+B_LO_W)'(r_p_tnn[TNN_W-1:A_LO_W]) * (A_HI_W+B_LO_W)'(r_qq2[B_LO_W-1:0]);
        r_pp11 <= (A_HI_W+B_HI_W)'(r_p_tnn[TNN_W-1:A_LO_W])
                  * (A_HI_W+B_HI_W)'(r_qq2[QQ_W-1:B_LO_W]);

        r_d2b <= r_d2;
        r_rhs <= (RHS_W'(r_pp11) << (A_LO_W + B_LO_W))
               + (RHS_W'(r_pp01) << B_LO_W)
               + (RHS_W'(r_pp10) << A_LO_W)
               + RHS_W'(r_pp00);

        r_hit <= lhs_cmp > rhs_cmp;
    end

    assign o_hit_valid = r_vld[R2_LAT-1];
    assign o_hit       = r_hit;

endmodule

// File: hw/rtl/ldwp_ctrl.sv
// Control state machine: sample accumulation, window walk and result emission.
module ldwp_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  ldwp_pkg::t_dp_status   i_status,
    output logic                   o_in_ready,
    output ldwp_pkg::t_ctl_cmd     o_cmd
);
    import ldwp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_ACC;
            end
            S_ACC: begin
                n_state = i_status.col_end ? S_WALK_CHECK : S_IDLE;
            end
            S_WALK_CHECK: begin
                if (!i_status.cur_kept || i_status.walk_done) begin
                    n_state = S_CLOSE;
                end else if (i_status.slot_kept) begin
                    n_state = S_WALK_WAIT;
                end
            end
            S_WALK_WAIT: begin
                if (i_status.hit_valid) n_state = S_WALK_CHECK;
            end
            S_CLOSE: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!i_status.emit_more) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_ACC: begin
                o_cmd.acc       = 1'b1;
                o_cmd.walk_init = i_status.col_end;
            end
            S_WALK_CHECK: begin
                if (i_status.cur_kept && !i_status.walk_done) begin
                    o_cmd.test_issue = i_status.slot_kept;
                    o_cmd.walk_next  = !i_status.slot_kept;
                end
            end
            S_WALK_WAIT: begin
                o_cmd.walk_apply = i_status.hit_valid;
            end
            S_CLOSE: begin
                o_cmd.close = 1'b1;
            end
            S_EMIT: begin
                o_cmd.pop    = i_status.emit_more && i_status.out_free;
                o_cmd.finish = !i_status.emit_more;
            end
            default: ;
        endcase
    end

`ifndef ASSERT_OFF
    a_hit_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.hit_valid |-> (r_state == S_WALK_WAIT))
        else $error("pair test result outside walk wait");
    a_acc_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == S_ACC))
        else $error("accepted item not accumulated");
`endif

endmodule

// File: hw/rtl/ldwp_dpath.sv
// Datapath: genotype row memory, dot accumulators, window state, pair test, output register.
module ldwp_dpath #(
    parameter int WINDOW      = 16,
    parameter int MAX_SAMPLES = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [ldwp_pkg::GENO_W-1:0]       i_genotype,
    input  logic [ldwp_pkg::SUM_W-1:0]        i_snp_sum,
    input  logic [ldwp_pkg::SSQ_W-1:0]        i_snp_sumsq_dev,
    input  logic [ldwp_pkg::FREQ_W-1:0]       i_allele_freq,
    input  logic                              i_initially_kept,
    input  logic                              i_last_sample,
    input  logic                              i_end_of_data,
    input  logic                              i_cfg_write,
    input  logic [ldwp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ldwp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  ldwp_pkg::t_ctl_cmd                i_cmd,
    output ldwp_pkg::t_dp_status              o_status,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [ldwp_pkg::IDX_W-1:0]        o_snp_index,
    output logic                              o_kept,
    output logic                              o_last_of_flush
);
    import ldwp_pkg::*;

    localparam int IW    = $clog2(WINDOW);
    localparam int FW    = $clog2(WINDOW + 1);
    localparam int AW    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int SCW   = $clog2(MAX_SAMPLES + 1);
    localparam int ROW_W = WINDOW * GENO_W;

    logic [THR_W-1:0] r_thr;
    logic [CNT_W-1:0] r_n;
    logic [WU_W-1:0]  r_wu;

    logic [IW-1:0]    r_head;
    logic [FW-1:0]    r_fill;
    logic [IDX_W-1:0] r_snp;
    logic [SCW-1:0]   r_samp;
    logic [FW-1:0]    r_k;
    logic [WINDOW-1:0] r_keep;

    logic [SUM_W-1:0]  r_sum  [WINDOW];
    logic [SSQ_W-1:0]  r_ssq  [WINDOW];
    logic [FREQ_W-1:0] r_freq [WINDOW];
    logic [DOT_W-1:0]  r_dot  [WINDOW];
    logic [SUM_W-1:0]  r_cur_sum;
    logic [SSQ_W-1:0]  r_cur_ssq;
    logic [FREQ_W-1:0] r_cur_freq;

    logic [GENO_W-1:0] r_geno;
    logic              r_last;
    logic              r_eod;
    logic              r_first;
    logic              r_inrange;
    logic [AW-1:0]     r_addr;

    logic [ROW_W-1:0]  r_mem [MAX_SAMPLES];
    logic [ROW_W-1:0]  r_rd_row;

    logic              r_out_valid;
    logic [IDX_W-1:0]  r_out_idx;
    logic              r_out_kept;
    logic              r_out_lof;

    logic [IW:0]       cur_sum;
    logic [IW-1:0]     cur;
    logic [IW:0]       ws_sum;
    logic [IW-1:0]     ws;
    logic [IW-1:0]     slot_off [WINDOW];
    logic [WINDOW-1:0] in_win;
    logic [ROW_W-1:0]  row_wr;
    logic [FW-1:0]     used;
    logic              out_free;
    logic              hit_valid;
    logic              hit;

    always_comb begin
        cur_sum = {1'b0, r_head} + (IW+1)'(r_fill);
        if (cur_sum >= (IW+1)'(WINDOW)) begin
            cur = IW'(cur_sum - (IW+1)'(WINDOW));
        end else begin
            cur = IW'(cur_sum);
        end
        ws_sum = {1'b0, r_head} + (IW+1)'(r_k);
        if (ws_sum >= (IW+1)'(WINDOW)) begin
            ws = IW'(ws_sum - (IW+1)'(WINDOW));
        end else begin
            ws = IW'(ws_sum);
        end
        for (int s = 0; s < WINDOW; s++) begin
            if (IW'(s) >= r_head) begin
                slot_off[s] = IW'(s) - r_head;
            end else begin
                slot_off[s] = IW'(s) + IW'(WINDOW) - r_head;
            end
            in_win[s] = FW'(slot_off[s]) < r_fill;
        end
        row_wr = r_rd_row;
        row_wr[cur*GENO_W +: GENO_W] = r_geno;
        if (r_wu < WU_W'(2)) begin
            used = FW'(2);
        end else if (int'(r_wu) > WINDOW) begin
            used = FW'(WINDOW);
        end else begin
            used = FW'(r_wu);
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_status.col_end   = r_last || r_eod;
        o_status.cur_kept  = r_keep[cur];
        o_status.walk_done = r_k >= r_fill;
        o_status.slot_kept = r_keep[ws];
        o_status.hit_valid = hit_valid;
        o_status.emit_more = r_eod ? (r_fill != '0) : (r_fill >= used);
        o_status.out_free  = out_free;
    end

    ldwp_r2_test u_r2 (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_issue     (i_cmd.test_issue),
        .i_dot       (r_dot[ws]),
        .i_sum_j     (r_sum[ws]),
        .i_sum_k     (r_cur_sum),
        .i_ssq_j     (r_ssq[ws]),
        .i_ssq_k     (r_cur_ssq),
        .i_thr       (r_thr),
        .i_n         (r_n),
        .o_hit_valid (hit_valid),
        .o_hit       (hit)
    );

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
            r_n   <= CNT_RESET;
            r_wu  <= WU_RESET;
        end else if (i_cfg_write) begin
            case (i_cfg_index)
                REG_THRESHOLD:    r_thr <= i_cfg_data[THR_W-1:0];
                REG_SAMPLE_COUNT: r_n   <= i_cfg_data[CNT_W-1:0];
                REG_WINDOW_USED:  r_wu  <= i_cfg_data[WU_W-1:0];
                default: ;
            endcase
        end
    end

    // genotype rows: one row per sample position, one 2-bit slot per window entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd_row <= r_mem[r_samp[AW-1:0]];
        end
        if (i_cmd.acc && r_inrange) begin
            r_mem[r_addr] <= row_wr;
        end
    end

    // payload state
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_geno    <= i_genotype;
            r_addr    <= r_samp[AW-1:0];
            r_first   <= r_samp == '0;
            r_inrange <= r_samp < SCW'(MAX_SAMPLES);
            if (r_samp == '0) begin
                r_sum[cur]  <= i_snp_sum;
                r_ssq[cur]  <= i_snp_sumsq_dev;
                r_freq[cur] <= i_allele_freq;
                r_cur_sum   <= i_snp_sum;
                r_cur_ssq   <= i_snp_sumsq_dev;
                r_cur_freq  <= i_allele_freq;
            end
        end
        if (i_cmd.acc && r_inrange) begin
            for (int s = 0; s < WINDOW; s++) begin
                if (in_win[s] && r_geno != GENO_MISSING
                        && r_rd_row[s*GENO_W +: GENO_W] != GENO_MISSING) begin
                    r_dot[s] <= (r_first ? '0 : r_dot[s])
                              + DOT_W'({2'b0, r_rd_row[s*GENO_W +: GENO_W]} * {2'b0, r_geno});
                end else if (r_first) begin
                    r_dot[s] <= '0;
                end
            end
        end
        if (i_cmd.pop) begin
            r_out_idx  <= r_snp + IDX_W'(1) - IDX_W'(r_fill);
            r_out_kept <= r_keep[r_head];
            r_out_lof  <= r_eod && (r_fill == FW'(1));
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_fill      <= '0;
            r_snp       <= '0;
            r_samp      <= '0;
            r_k         <= '0;
            r_keep      <= '0;
            r_last      <= 1'b0;
            r_eod       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_last <= i_last_sample;
                r_eod  <= i_end_of_data;
                if (r_samp == '0) begin
                    r_keep[cur] <= i_initially_kept;
                end
                if (r_samp < SCW'(MAX_SAMPLES)) begin
                    r_samp <= r_samp + SCW'(1);
                end
            end
            if (i_cmd.acc && (r_last || r_eod)) begin
                r_samp <= '0;
            end
            if (i_cmd.walk_init) begin
                r_k <= '0;
            end
            if (i_cmd.walk_next) begin
                r_k <= r_k + FW'(1);
            end
            if (i_cmd.walk_apply) begin
                r_k <= r_k + FW'(1);
                if (hit) begin
                    if (r_cur_freq < r_freq[ws]) begin
                        r_keep[cur] <= 1'b0;
                    end else begin
                        r_keep[ws] <= 1'b0;
                    end
                end
            end
            if (i_cmd.close) begin
                r_fill <= r_fill + FW'(1);
            end
            if (i_cmd.pop) begin
                r_fill <= r_fill - FW'(1);
                r_head <= (r_head == IW'(WINDOW - 1)) ? '0 : r_head + IW'(1);
            end
            if (i_cmd.finish) begin
                if (r_eod) begin
                    r_head <= '0;
                    r_snp  <= '0;
                end else begin
                    r_snp <= r_snp + IDX_W'(1);
                end
            end
            if (i_cmd.pop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_snp_index     = r_out_idx;
    assign o_kept          = r_out_kept;
    assign o_last_of_flush = r_out_lof;

`ifndef ASSERT_OFF
    a_pop_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an untaken result");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(WINDOW))
        else $error("window fill above window length");
`endif

endmodule

// File: hw/rtl/ld_window_pruner.sv
// Top level of the LD window pruner: controller plus datapath.
//
// Input channel (i_valid / o_ready): one genotype per item; the first item of a
// column also carries the column's sum, centred sum of squares, allele frequency
// and initial keep flag. last_sample ends a column, end_of_data ends the stream
// and flushes the window.
// Output channel (o_valid / i_ready): one item per SNP whose keep decision is
// final, in stream order; last_of_flush marks the final item of a flush.
// Configuration channel (i_cfg_valid / o_cfg_ready, always ready): index 0
// threshold, 1 sample count, 2 window length; write only while idle.
// Sequencing: each sample is accepted and then accumulated, a read-modify-write
// of the genotype row memory; no input is taken while it accumulates. At a column
// end the window walk sends each kept window SNP through the 5-stage pair test
// and waits for its result, skipping pruned ones; then the column is closed, one
// result is emitted per take by the receiver, and the controller returns to idle.
// A finished result waits in the output register; a stalled receiver holds the
// emit sequence, and input is taken again once the last result is registered.
// Reset empties the window, clears all keep flags and counters and restores the
// register defaults; the genotype memory is not cleared.
module ld_window_pruner #(
    parameter int WINDOW      = 16,
    parameter int MAX_SAMPLES = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [ldwp_pkg::GENO_W-1:0]       i_genotype,
    input  logic [ldwp_pkg::SUM_W-1:0]        i_snp_sum,
    input  logic [ldwp_pkg::SSQ_W-1:0]        i_snp_sumsq_dev,
    input  logic [ldwp_pkg::FREQ_W-1:0]       i_allele_freq,
    input  logic                              i_initially_kept,
    input  logic                              i_last_sample,
    input  logic                              i_end_of_data,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [ldwp_pkg::IDX_W-1:0]        o_snp_index,
    output logic                              o_kept,
    output logic                              o_last_of_flush,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ldwp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ldwp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import ldwp_pkg::*;

    t_ctl_cmd   cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    ldwp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_status   (status),
        .o_in_ready (o_ready),
        .o_cmd      (cmd)
    );

    ldwp_dpath #(
        .WINDOW      (WINDOW),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_genotype       (i_genotype),
        .i_snp_sum        (i_snp_sum),
        .i_snp_sumsq_dev  (i_snp_sumsq_dev),
        .i_allele_freq    (i_allele_freq),
        .i_initially_kept (i_initially_kept),
        .i_last_sample    (i_last_sample),
        .i_end_of_data    (i_end_of_data),
        .i_cfg_write      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_out_ready      (i_ready),
        .o_out_valid      (o_valid),
        .o_snp_index      (o_snp_index),
        .o_kept           (o_kept),
        .o_last_of_flush  (o_last_of_flush)
    );

endmodule

// File: bench/ldwp_checker.sv
// Checker for the LD window pruner: predicts keep decisions from accepted items and compares.
module ldwp_checker #(
    parameter int WINDOW      = 16,
    parameter int MAX_SAMPLES = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic                            o_ready,
    input  logic [ldwp_pkg::GENO_W-1:0]     i_genotype,
    input  logic [ldwp_pkg::SUM_W-1:0]      i_snp_sum,
    input  logic [ldwp_pkg::SSQ_W-1:0]      i_snp_sumsq_dev,
    input  logic [ldwp_pkg::FREQ_W-1:0]     i_allele_freq,
    input  logic                            i_initially_kept,
    input  logic                            i_last_sample,
    input  logic                            i_end_of_data,
    input  logic                            o_valid,
    input  logic                            i_ready,
    input  logic [ldwp_pkg::IDX_W-1:0]      o_snp_index,
    input  logic                            o_kept,
    input  logic                            o_last_of_flush,
    input  logic                            i_cfg_valid,
    input  logic                            o_cfg_ready,
    input  logic [ldwp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ldwp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_pending,
    output int                              o_errors
);
    import ldwp_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             kept;
        logic             last;
    } t_decision;

    t_decision decisions_due[$];

    logic [GENO_W-1:0] geno_rows [WINDOW*MAX_SAMPLES];
    logic [SUM_W-1:0]  slot_sum  [WINDOW];
    logic [SSQ_W-1:0]  slot_ssq  [WINDOW];
    logic [FREQ_W-1:0] slot_freq [WINDOW];
    logic              slot_keep [WINDOW];
    logic [DOT_W-1:0]  slot_dot  [WINDOW];
    logic [IDX_W-1:0]  snp_pos;
    int unsigned       sample_pos;
    int unsigned       fill;
    int unsigned       head;
    logic [THR_W-1:0]  thr;
    logic [CNT_W-1:0]  n_samples;
    logic [WU_W-1:0]   win_len;
    int                errors;

    assign o_pending = decisions_due.size();
    assign o_errors  = errors;

    function automatic bit r2_above(int unsigned dot, int unsigned sj, int unsigned sk,
                                    int unsigned qj, int unsigned qk);
        longint          d;
        longint unsigned ad;
        logic [127:0]    lhs;
        logic [127:0]    rhs;
        d   = longint'(dot) * longint'(n_samples) - longint'(sj) * longint'(sk);
        ad  = (d < 0) ? longint'(-d) : longint'(d);
        lhs = {64'd0, ad * ad} << 32;
        rhs = 128'(thr) * 128'(n_samples) * 128'(n_samples) * 128'(qj) * 128'(qk);
        return lhs > rhs;
    endfunction

    task automatic absorb_item();
        int unsigned cur;
        int unsigned s;
        int unsigned total;
        int unsigned used;
        logic [IDX_W-1:0] first_idx;
        logic [1:0]  gs;
        t_decision   dec;
        cur = (head + fill) % WINDOW;
        if (sample_pos == 0) begin
            for (int k = 0; k < WINDOW; k++) slot_dot[k] = '0;
            slot_sum[cur]  = i_snp_sum;
            slot_ssq[cur]  = i_snp_sumsq_dev;
            slot_freq[cur] = i_allele_freq;
            slot_keep[cur] = i_initially_kept;
        end
        if (sample_pos < MAX_SAMPLES) begin
            for (int k = 0; k < fill; k++) begin
                s  = (head + k) % WINDOW;
                gs = geno_rows[s*MAX_SAMPLES + sample_pos];
                if (gs != GENO_MISSING && i_genotype != GENO_MISSING)
                    slot_dot[s] = slot_dot[s] + DOT_W'(gs * i_genotype);
            end
            geno_rows[cur*MAX_SAMPLES + sample_pos] = i_genotype;
            sample_pos++;
        end
        if (!i_last_sample && !i_end_of_data) return;
        if (slot_keep[cur]) begin
            for (int k = 0; k < fill; k++) begin
                s = (head + k) % WINDOW;
                if (!slot_keep[s]) continue;
                if (r2_above(slot_dot[s], slot_sum[s], slot_sum[cur],
                             slot_ssq[s], slot_ssq[cur])) begin
                    if (slot_freq[cur] < slot_freq[s]) begin
                        slot_keep[cur] = 1'b0;
                        break;
                    end
                    slot_keep[s] = 1'b0;
                end
            end
        end
        total     = fill + 1;
        first_idx = snp_pos - IDX_W'(fill);
        used      = win_len;
        if (used < 2) used = 2;
        if (used > WINDOW) used = WINDOW;
        if (i_end_of_data) begin
            for (int k = 0; k < total; k++) begin
                s = (head + k) % WINDOW;
                dec.idx  = first_idx + IDX_W'(k);
                dec.kept = slot_keep[s];
                dec.last = (k + 1 == total);
                decisions_due.push_back(dec);
            end
            fill    = 0;
            head    = 0;
            snp_pos = '0;
        end else begin
            fill = total;
            while (fill > used - 1) begin
                dec.idx  = first_idx;
                dec.kept = slot_keep[head];
                dec.last = 1'b0;
                decisions_due.push_back(dec);
                first_idx++;
                head = (head + 1) % WINDOW;
                fill--;
            end
            snp_pos++;
        end
        sample_pos = 0;
    endtask

    always @(posedge i_clk) begin
        t_decision dec;
        if (!i_rst_n) begin
            decisions_due.delete();
            for (int k = 0; k < WINDOW; k++) begin
                slot_keep[k] = 1'b0;
                slot_dot[k]  = '0;
            end
            snp_pos    = '0;
            sample_pos = 0;
            fill       = 0;
            head       = 0;
            thr        = THR_RESET;
            n_samples  = CNT_RESET;
            win_len    = WU_RESET;
        end else begin
            if (o_valid && i_ready) begin
                if (decisions_due.size() == 0) begin
                    $error("unexpected result: snp_index %0d kept %0b", o_snp_index, o_kept);
                    errors++;
                end else begin
                    dec = decisions_due.pop_front();
                    if (o_snp_index !== dec.idx) begin
                        $error("snp_index: expected %0d actual %0d", dec.idx, o_snp_index);
                        errors++;
                    end
                    if (o_kept !== dec.kept) begin
                        $error("kept: expected %0b actual %0b", dec.kept, o_kept);
                        errors++;
                    end
                    if (o_last_of_flush !== dec.last) begin
                        $error("last_of_flush: expected %0b actual %0b",
                               dec.last, o_last_of_flush);
                        errors++;
                    end
                end
            end
            if (i_valid && o_ready) absorb_item();
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_THRESHOLD:    thr       = i_cfg_data[THR_W-1:0];
                    REG_SAMPLE_COUNT: n_samples = i_cfg_data[CNT_W-1:0];
                    REG_WINDOW_USED:  win_len   = i_cfg_data[WU_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// File: bench/tb_ld_window_pruner.sv
// Testbench top for the LD window pruner: stimulus, reset, receiver stalls and verdict.
module tb_ld_window_pruner;
    import ldwp_pkg::*;

    localparam int LIMIT = 1000000;
    localparam int SETTLE = 200;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic [GENO_W-1:0]     i_genotype;
    logic [SUM_W-1:0]      i_snp_sum;
    logic [SSQ_W-1:0]      i_snp_sumsq_dev;
    logic [FREQ_W-1:0]     i_allele_freq;
    logic                  i_initially_kept;
    logic                  i_last_sample;
    logic                  i_end_of_data;
    logic                  o_valid;
    logic                  i_ready;
    logic [IDX_W-1:0]      o_snp_index;
    logic                  o_kept;
    logic                  o_last_of_flush;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int pending;
    int errors;
    int cycles;
    bit hold_req;
    int hold_left;
    int burst_left;
    bit gaps_on;
    int cur_n;
    int col_geno [4100];
    int prev_geno [4100];
    int prev_freq;

    ld_window_pruner dut (.*);

    ldwp_checker chk (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_genotype, .i_snp_sum, .i_snp_sumsq_dev,
        .i_allele_freq, .i_initially_kept, .i_last_sample, .i_end_of_data, .o_valid,
        .i_ready, .o_snp_index, .o_kept, .o_last_of_flush, .i_cfg_valid, .o_cfg_ready,
        .i_cfg_index, .i_cfg_data, .o_pending(pending), .o_errors(errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Receiver: ready follows a randomly redrawn pattern of four modes; a requested hold keeps ready low.
    initial begin
        int mode;
        mode = 0;
        hold_left = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (cycles % 64 == 0) mode = $urandom_range(0, 3);
            if (hold_left > 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 400;
                i_ready <= 1'b0;
            end else begin
                case (mode)
                    0: i_ready <= 1'b1;
                    1: i_ready <= ($urandom_range(0, 1) == 0);
                    2: i_ready <= ($urandom_range(0, 3) == 0);
                    default: i_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    task automatic send_item(int g, int sum, int ssq, int freq, bit kept, bit last, bit eod);
        i_valid          <= 1'b1;
        i_genotype       <= GENO_W'(g);
        i_snp_sum        <= SUM_W'(sum);
        i_snp_sumsq_dev  <= SSQ_W'(ssq);
        i_allele_freq    <= FREQ_W'(freq);
        i_initially_kept <= kept;
        i_last_sample    <= last;
        i_end_of_data    <= eod;
        do @(posedge i_clk); while (!o_ready);
        if (burst_left == 0) begin
            if (gaps_on) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end else begin
            burst_left--;
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(data);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Builds one column, often correlated with the previous one, and sends it, or with early set only a prefix of it.
    task automatic send_column(int len, bit eod, bit early);
        int mode;
        int s;
        int ss;
        int g;
        int freq;
        int stop;
        longint q;
        bit kept;
        mode = $urandom_range(0, 9);
        s = 0;
        ss = 0;
        for (int i = 0; i < len; i++) begin
            if (mode < 4)
                g = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : prev_geno[i];
            else if (mode == 4)
                g = prev_geno[0] % 3;
            else
                g = ($urandom_range(0, 15) == 0) ? 3 : $urandom_range(0, 2);
            col_geno[i] = g;
            if (g != 3) begin
                s += g;
                ss += g * g;
            end
        end
        q = longint'(ss) * 256 - (longint'(s) * s * 256) / cur_n;
        if (q < 0) q = 0;
        if (q > 4194304) q = 4194304;
        case ($urandom_range(0, 9))
            0: begin s = 8192; q = 4194304; end
            1: q = 0;
            default: ;
        endcase
        freq = ($urandom_range(0, 3) == 0) ? prev_freq : $urandom_range(0, 32768);
        prev_freq = freq;
        kept = ($urandom_range(0, 7) != 0);
        stop = early ? $urandom_range(0, len - 1) : len - 1;
        for (int i = 0; i <= stop; i++) begin
            if (i == 0)
                send_item(col_geno[i], s, int'(q), freq, kept, i == len - 1,
                          eod && i == stop);
            else
                send_item(col_geno[i], $urandom, $urandom, $urandom, $urandom_range(0, 1),
                          i == len - 1, eod && i == stop);
        end
        for (int i = 0; i < len; i++) prev_geno[i] = col_geno[i];
    endtask

    task automatic run_phase(int thr, int n, int w, int ncols, bit shrink, bit early);
        wait_drained();
        cfg_write(REG_THRESHOLD, thr);
        cfg_write(REG_SAMPLE_COUNT, n);
        cfg_write(REG_WINDOW_USED, w);
        cur_n = n;
        for (int i = 0; i < 4100; i++) prev_geno[i] = $urandom_range(0, 2);
        for (int c = 0; c < ncols; c++) begin
            if (shrink && c == ncols / 2 && c != 0) begin
                wait_drained();
                cfg_write(REG_WINDOW_USED, $urandom_range(0, 4));
            end
            send_column(n, c == ncols - 1, early && c == ncols - 1);
        end
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_genotype       <= '0;
        i_snp_sum        <= '0;
        i_snp_sumsq_dev  <= '0;
        i_allele_freq    <= '0;
        i_initially_kept <= 1'b0;
        i_last_sample    <= 1'b0;
        i_end_of_data    <= 1'b0;
        i_cfg_valid      <= 1'b0;
        i_cfg_index      <= '0;
        i_cfg_data       <= '0;
        hold_req = 1'b0;
        burst_left = 0;
        gaps_on = 1'b1;
        prev_freq = 100;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        cfg_write(2'd3, 17'h1FFFF);
        run_phase(0, 4, 2, 4, 1'b0, 1'b0);
        run_phase(65536, 1, 16, 4, 1'b0, 1'b0);
        run_phase(13107, 3, 31, 2, 1'b0, 1'b1);

        for (int p = 0; p < 9; p++) begin
            int thr;
            int n;
            case ($urandom_range(0, 5))
                0: thr = 0;
                1: thr = 65536;
                default: thr = $urandom_range(0, 65536);
            endcase
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
            gaps_on = (p % 3 != 0);
            if (p == 2) hold_req = 1'b1;
            run_phase(thr, n, $urandom_range(0, 31), $urandom_range(3, 12),
                      $urandom_range(0, 2) == 0, $urandom_range(0, 5) == 0);
        end

        wait_drained();
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
